// ----- src/smvt_pkg.sv -----
// Shared types and constants for the stack machine with variable table
`timescale 1ns / 1ps
`default_nettype none

package smvt_pkg;

    localparam int DATA_W          = 32;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 3;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int VAR_ENTRIES_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_LOAD  = 3'd1,
        CMD_STORE = 3'd2,
        CMD_ADD   = 3'd3,
        CMD_SUB   = 3'd4
    } smvt_cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_FULL      = 3'd4
    } smvt_status_e;

    typedef struct packed {
        logic accept;
        logic commit;
    } smvt_ctl_t;

    typedef struct packed {
        logic out_free;
    } smvt_sts_t;

endpackage

`default_nettype wire

// ----- src/smvt_ctrl.sv -----
// Controller state machine: request intake and commit sequencing
`timescale 1ns / 1ps
`default_nettype none

module smvt_ctrl
    import smvt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  smvt_sts_t      sts,
    output smvt_ctl_t      ctl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the result register can take the result
                ctl.commit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/smvt_datapath.sv -----
// Datapath: value stack memory, variable table, ALU and result register
`timescale 1ns / 1ps
`default_nettype none

module smvt_datapath
    import smvt_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VAR_ENTRIES = VAR_ENTRIES_DEF,
    localparam int CW         = $clog2(STACK_DEPTH + 1)
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  smvt_ctl_t                       ctl,
    output smvt_sts_t                       sts,
    input  wire logic [CMD_W-1:0]           in_cmd,
    input  wire logic signed [DATA_W-1:0]   in_const,
    input  wire logic [DATA_W-1:0]          in_key,
    input  wire logic                       in_last,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [DATA_W-1:0]        out_top,
    output logic [CW-1:0]                   out_count,
    output logic [STATUS_W-1:0]             out_status,
    output logic                            out_last
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int IW = (VAR_ENTRIES > 1) ? $clog2(VAR_ENTRIES) : 1;
    localparam int UW = $clog2(VAR_ENTRIES + 1);

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] var_mem   [VAR_ENTRIES];
    logic [DATA_W-1:0] keys_reg  [VAR_ENTRIES];

    logic [CW-1:0]       level_reg;
    logic [CW-1:0]       level_next;
    logic [UW-1:0]       used_reg;
    logic [UW-1:0]       used_next;
    logic [DATA_W-1:0]   tos_reg;
    logic [DATA_W-1:0]   tos_next;

    logic [CMD_W-1:0]    cmd_reg;
    logic [DATA_W-1:0]   cval_reg;
    logic [DATA_W-1:0]   ikey_reg;
    logic                last_reg;
    logic                hit_reg;
    logic [IW-1:0]       hidx_reg;
    logic [DATA_W-1:0]   below_reg;
    logic [DATA_W-1:0]   vrd_reg;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   top_out_reg;
    logic [CW-1:0]       cnt_out_reg;
    logic [STATUS_W-1:0] st_out_reg;
    logic                last_out_reg;

    logic                match_hit;
    logic [IW-1:0]       match_idx;
    logic [CW-1:0]       level_m1;
    logic [CW-1:0]       level_m2;
    logic [DATA_W-1:0]   below_pop;
    logic [DATA_W-1:0]   alu_res;
    logic [STATUS_W-1:0] status;
    logic                stk_we;
    logic [AW-1:0]       stk_waddr;
    logic [DATA_W-1:0]   stk_wdata;
    logic                var_we;
    logic [IW-1:0]       var_waddr;
    logic                key_we;

    assign level_m1 = level_reg - CW'(1);
    assign level_m2 = level_reg - CW'(2);

    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = VAR_ENTRIES - 1; i >= 0; i--)
        begin
            if ((UW'(i) < used_reg) && (keys_reg[i] == in_key))
            begin
                match_hit = 1'b1;
                match_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg   <= in_cmd;
            cval_reg  <= in_const;
            ikey_reg  <= in_key;
            last_reg  <= in_last;
            hit_reg   <= match_hit;
            hidx_reg  <= match_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (ctl.accept)
        begin
            below_reg <= stack_mem[level_m2[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && var_we)
        begin
            var_mem[var_waddr] <= tos_reg;
        end
        if (ctl.accept)
        begin
            vrd_reg <= var_mem[match_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && key_we)
        begin
            keys_reg[var_waddr] <= ikey_reg;
        end
    end

    assign below_pop = (level_reg == CW'(1)) ? '0 : below_reg;
    assign alu_res   = (cmd_reg == CMD_ADD) ? (below_reg + tos_reg) : (below_reg - tos_reg);

    always_comb
    begin
        status     = ST_OK;
        level_next = level_reg;
        used_next  = used_reg;
        tos_next   = tos_reg;
        stk_we     = 1'b0;
        stk_waddr  = level_reg[AW-1:0];
        stk_wdata  = cval_reg;
        var_we     = 1'b0;
        var_waddr  = hidx_reg;
        key_we     = 1'b0;
        unique case (cmd_reg)
            CMD_PUSH:
            begin
                if (level_reg >= CW'(STACK_DEPTH))
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    stk_we     = 1'b1;
                    level_next = level_reg + CW'(1);
                    tos_next   = cval_reg;
                end
            end
            CMD_LOAD:
            begin
                if (!hit_reg)
                begin
                    status = ST_UNKNOWN;
                end
                else if (level_reg >= CW'(STACK_DEPTH))
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = vrd_reg;
                    level_next = level_reg + CW'(1);
                    tos_next   = vrd_reg;
                end
            end
            CMD_STORE:
            begin
                if (level_reg == '0)
                begin
                    status = ST_UNDERFLOW;
                end
                else if (hit_reg)
                begin
                    var_we     = 1'b1;
                    level_next = level_m1;
                    tos_next   = below_pop;
                end
                else if (used_reg >= UW'(VAR_ENTRIES))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    var_we     = 1'b1;
                    key_we     = 1'b1;
                    var_waddr  = used_reg[IW-1:0];
                    used_next  = used_reg + UW'(1);
                    level_next = level_m1;
                    tos_next   = below_pop;
                end
            end
            CMD_ADD, CMD_SUB:
            begin
                if (level_reg < CW'(2))
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = level_m2[AW-1:0];
                    stk_wdata  = alu_res;
                    level_next = level_m1;
                    tos_next   = alu_res;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            used_reg      <= '0;
            tos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
            begin
                level_reg     <= level_next;
                used_reg      <= used_next;
                tos_reg       <= tos_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            top_out_reg  <= tos_next;
            cnt_out_reg  <= level_next;
            st_out_reg   <= status;
            last_out_reg <= last_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_top      = top_out_reg;
    assign out_count    = cnt_out_reg;
    assign out_status   = st_out_reg;
    assign out_last     = last_out_reg;

endmodule

`default_nettype wire

// ----- src/stack_machine_with_variable_table_unit.sv -----
// Top level of the stack machine with variable table
//
// channel  dir  tdata                                      tuser        tlast
// s_axis   in   [31:0] const_value, [63:32] name_key       [2:0] cmd    last_instruction
// m_axis   out  [31:0] top_value, [32+:CW] stack_count     [2:0] status program_done
//
// Each request passes an accept state, which takes it, compares the name against all
// table keys and reads the stack memory and variable memory; a commit state then
// commits the stack and table updates and loads the result register.
// A request is taken while the previous result still waits in the result register.
// A stalled result holds the commit cycle; reset clears the stack level and table fill.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_with_variable_table_unit
    import smvt_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VAR_ENTRIES = VAR_ENTRIES_DEF,
    localparam int CW         = $clog2(STACK_DEPTH + 1),
    localparam int OUT_W      = ((DATA_W + CW + 7) / 8) * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [2*DATA_W-1:0]   s_axis_tdata,  // const_value, name_key
    input  wire logic [CMD_W-1:0]      s_axis_tuser,  // cmd
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_W-1:0]           m_axis_tdata,  // top_value, stack_count, zero pad
    output logic [STATUS_W-1:0]        m_axis_tuser,  // status
    output logic                       m_axis_tlast
);

    smvt_ctl_t                 ctl;
    smvt_sts_t                 sts;
    logic signed [DATA_W-1:0]  top_value;
    logic [CW-1:0]             stack_count;

    smvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    smvt_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VAR_ENTRIES (VAR_ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_cmd     (s_axis_tuser),
        .in_const   (s_axis_tdata[DATA_W-1:0]),
        .in_key     (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .in_last    (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_top    (top_value),
        .out_count  (stack_count),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({stack_count, top_value});

endmodule

`default_nettype wire

// ----- src/smvt_checker.sv -----
// Port-level checker for the stack machine top level and its bind
`timescale 1ns / 1ps
`default_nettype none

module smvt_checker
    import smvt_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int CW         = $clog2(STACK_DEPTH + 1),
    localparam int OUT_W      = ((DATA_W + CW + 7) / 8) * 8
)
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [OUT_W-1:0]    m_axis_tdata,
    input wire logic [STATUS_W-1:0] m_axis_tuser
);

    logic [CW-1:0] cnt;
    logic [CW-1:0] last_cnt_reg;

    assign cnt = m_axis_tdata[DATA_W +: CW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cnt_reg <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            last_cnt_reg <= cnt;
        end
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (cnt <= CW'(STACK_DEPTH)))
        else $error("stack count beyond depth");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (cnt == '0)) |-> (m_axis_tdata[DATA_W-1:0] == '0))
        else $error("nonzero top on empty stack");

    a_error_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (cnt == last_cnt_reg))
        else $error("failed request changed stack depth");

    a_one_request_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while previous one executes");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind stack_machine_with_variable_table_unit smvt_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_smvt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the stack machine with variable table
`timescale 1ns / 1ps

module tb_top;
    import smvt_pkg::*;

    localparam int CNT_W      = $clog2(STACK_DEPTH_DEF + 1);
    localparam int RES_W      = ((DATA_W + CNT_W + 7) / 8) * 8;
    localparam int CYCLE_MAX  = 200000;
    localparam int POOL_SIZE  = 24;
    localparam int SHOW_MAX   = 10;

    localparam logic [CMD_W-1:0] CMD_RSV_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSV_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSV_LAST  = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]   top;
        logic [CNT_W-1:0]    depth;
        logic [STATUS_W-1:0] status;
        logic                done;
    } sm_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [2*DATA_W-1:0]   s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [RES_W-1:0]      m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  m_axis_tlast;

    logic [DATA_W-1:0]     stk_mem [STACK_DEPTH_DEF];
    int unsigned           stk_level;
    logic [DATA_W-1:0]     var_key [VAR_ENTRIES_DEF];
    logic [DATA_W-1:0]     var_val [VAR_ENTRIES_DEF];
    int unsigned           var_cnt;
    logic [DATA_W-1:0]     key_pool [POOL_SIZE];

    sm_result_t            pending_q [$];
    int                    err_cnt;
    int                    checked_cnt;
    int                    instr_cnt;
    int                    status_tally [5];
    int                    cycle_cnt;
    bit                    idle_on = 1'b1;

    always #10 clk = ~clk;

    stack_machine_with_variable_table_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic int find_key(input logic [DATA_W-1:0] key);
        for (int i = 0; i < int'(var_cnt); i++)
        begin
            if (var_key[i] == key)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [DATA_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
        begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom();
    endfunction

    function automatic logic [DATA_W-1:0] pick_const();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] fresh_key();
        logic [DATA_W-1:0] k;
        k = $urandom();
        while (find_key(k) >= 0)
        begin
            k = $urandom();
        end
        return k;
    endfunction

    task automatic execute_instr(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] cval,
                                 input logic [DATA_W-1:0] key, input logic last);
        sm_result_t r;
        int idx;
        logic [STATUS_W-1:0] st;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        st = ST_OK;
        case (op)
            CMD_PUSH:
            begin
                if (stk_level >= STACK_DEPTH_DEF)
                begin
                    st = ST_OVERFLOW;
                end
                else
                begin
                    stk_mem[stk_level] = cval;
                    stk_level++;
                end
            end
            CMD_LOAD:
            begin
                idx = find_key(key);
                if (idx < 0)
                begin
                    st = ST_UNKNOWN;
                end
                else if (stk_level >= STACK_DEPTH_DEF)
                begin
                    st = ST_OVERFLOW;
                end
                else
                begin
                    stk_mem[stk_level] = var_val[idx];
                    stk_level++;
                end
            end
            CMD_STORE:
            begin
                idx = find_key(key);
                if (stk_level == 0)
                begin
                    st = ST_UNDERFLOW;
                end
                else if (idx >= 0)
                begin
                    var_val[idx] = stk_mem[stk_level - 1];
                    stk_level--;
                end
                else if (var_cnt >= VAR_ENTRIES_DEF)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    var_key[var_cnt] = key;
                    var_val[var_cnt] = stk_mem[stk_level - 1];
                    var_cnt++;
                    stk_level--;
                end
            end
            CMD_ADD, CMD_SUB:
            begin
                if (stk_level < 2)
                begin
                    st = ST_UNDERFLOW;
                end
                else
                begin
                    a = stk_mem[stk_level - 2];
                    b = stk_mem[stk_level - 1];
                    stk_mem[stk_level - 2] = (op == CMD_ADD) ? a + b : a - b;
                    stk_level--;
                end
            end
            default:
            begin
            end
        endcase
        r.top    = (stk_level > 0) ? stk_mem[stk_level - 1] : '0;
        r.depth  = CNT_W'(stk_level);
        r.status = st;
        r.done   = last;
        pending_q.push_back(r);
        status_tally[st]++;
    endtask

    task automatic send_instr(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] cval,
                              input logic [DATA_W-1:0] key, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {key, cval};
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        execute_instr(op, cval, key, last);
        instr_cnt++;
    endtask

    task automatic drain_stack();
        while (stk_level > 1)
        begin
            send_instr($urandom_range(0, 1) ? CMD_ADD : CMD_SUB, $urandom(), $urandom(),
                       1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_basic_ops();
        send_instr(CMD_ADD,   32'h0,         32'h0,         1'b0);
        send_instr(CMD_SUB,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_instr(CMD_STORE, 32'h0,         32'h0,         1'b0);
        send_instr(CMD_LOAD,  32'h0,         32'h0,         1'b0);
        send_instr(CMD_LOAD,  32'h0,         32'hFFFF_FFFF, 1'b0);
        send_instr(CMD_PUSH,  32'h7FFF_FFFF, 32'h0,         1'b0);
        send_instr(CMD_SUB,   32'h0,         32'h0,         1'b0);
        send_instr(CMD_PUSH,  32'h1,         32'hFFFF_FFFF, 1'b0);
        send_instr(CMD_ADD,   32'h0,         32'h0,         1'b0);
        send_instr(CMD_PUSH,  32'h1,         32'h0,         1'b0);
        send_instr(CMD_SUB,   32'h0,         32'h0,         1'b0);
        send_instr(CMD_PUSH,  32'h8000_0000, 32'h0,         1'b0);
        send_instr(CMD_SUB,   32'h0,         32'h0,         1'b0);
        send_instr(CMD_STORE, 32'h0,         32'hFFFF_FFFF, 1'b0);
        send_instr(CMD_PUSH,  32'h0,         32'h0,         1'b0);
        send_instr(CMD_STORE, 32'hFFFF_FFFF, 32'h0,         1'b1);
        send_instr(CMD_LOAD,  32'h0,         32'hFFFF_FFFF, 1'b0);
        send_instr(CMD_STORE, 32'h0,         32'h0,         1'b0);
        send_instr(CMD_LOAD,  32'h0,         32'h0,         1'b0);
        send_instr(CMD_RSV_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_instr(CMD_RSV_MID,   32'h0,         32'h0,         1'b1);
        send_instr(CMD_RSV_LAST,  32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b1);
        send_instr(CMD_PUSH,  32'h8000_0000, 32'h0,         1'b1);
    endtask

    task automatic test_random_program(input int count);
        bit build;
        int seg_left;
        int r;
        logic [CMD_W-1:0] op;
        build = 1'b1;
        seg_left = $urandom_range(20, 80);
        for (int i = 0; i < count; i++)
        begin
            if (seg_left == 0)
            begin
                build = !build;
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (build)
            begin
                op = (r < 40) ? CMD_PUSH : (r < 60) ? CMD_LOAD : (r < 72) ? CMD_STORE :
                     (r < 82) ? CMD_ADD : (r < 94) ? CMD_SUB : CMD_RSV_FIRST;
            end
            else
            begin
                op = (r < 12) ? CMD_PUSH : (r < 22) ? CMD_LOAD : (r < 55) ? CMD_STORE :
                     (r < 75) ? CMD_ADD : (r < 95) ? CMD_SUB : CMD_RSV_FIRST;
            end
            if (op == CMD_RSV_FIRST)
            begin
                op = CMD_W'($urandom_range(CMD_RSV_FIRST, CMD_RSV_LAST));
            end
            send_instr(op, pick_const(), pick_key(), $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic test_stack_limit();
        while (stk_level < STACK_DEPTH_DEF)
        begin
            send_instr(CMD_PUSH, pick_const(), $urandom(), 1'b0);
        end
        send_instr(CMD_PUSH, $urandom(), $urandom(), 1'b0);
        if (var_cnt > 0)
        begin
            send_instr(CMD_LOAD, $urandom(), var_key[$urandom_range(0, var_cnt - 1)], 1'b0);
        end
        send_instr(CMD_LOAD, $urandom(), fresh_key(), 1'b1);
        drain_stack();
    endtask

    task automatic test_table_limit();
        drain_stack();
        for (int i = 0; i <= VAR_ENTRIES_DEF; i++)
        begin
            send_instr(CMD_PUSH, $urandom(), $urandom(), 1'b0);
            send_instr(CMD_STORE, $urandom(), fresh_key(), 1'b0);
        end
        send_instr(CMD_PUSH, $urandom(), $urandom(), 1'b0);
        send_instr(CMD_STORE, $urandom(), var_key[0], 1'b0);
        send_instr(CMD_LOAD, $urandom(), var_key[0], 1'b1);
        drain_stack();
    endtask

    task automatic report_mismatch(input string what, input sm_result_t want,
                                   input sm_result_t got);
        err_cnt++;
        if (err_cnt <= SHOW_MAX)
        begin
            $display("[%0t] %s: exp top=%h cnt=%0d st=%0d done=%b,",
                     $time, what, want.top, want.depth, want.status, want.done,
                     " got top=%h cnt=%0d st=%0d done=%b",
                     got.top, got.depth, got.status, got.done);
        end
    endtask

    always @(posedge clk)
    begin
        sm_result_t got;
        sm_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.top    = m_axis_tdata[DATA_W-1:0];
            got.depth  = m_axis_tdata[DATA_W +: CNT_W];
            got.status = m_axis_tuser;
            got.done   = m_axis_tlast;
            if (pending_q.size() == 0)
            begin
                report_mismatch("unexpected result", '0, got);
            end
            else
            begin
                want = pending_q.pop_front();
                checked_cnt++;
                if (got.top !== want.top || got.depth !== want.depth ||
                    got.status !== want.status || got.done !== want.done)
                begin
                    report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    initial
    begin
        int n;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            m_axis_tready <= 1'b1;
            if (!idle_on)
            begin
                @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 24);
                repeat (n) @(posedge clk);
                if ($urandom_range(0, 2) == 0)
                begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(1, 14);
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_MAX)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     pending_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        stk_level = 0;
        var_cnt   = 0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom();
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_random_program(500);
        test_stack_limit();
        test_table_limit();
        idle_on = 1'b0;
        test_random_program(200);
        s_axis_tvalid <= 1'b0;

        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("%0d instructions sent, %0d results checked, %0d errors",
                 instr_cnt, checked_cnt, err_cnt);
        $display("status counts: ok %0d, overflow %0d, underflow %0d, unknown %0d, full %0d",
                 status_tally[ST_OK], status_tally[ST_OVERFLOW], status_tally[ST_UNDERFLOW],
                 status_tally[ST_UNKNOWN], status_tally[ST_FULL]);
        if (err_cnt == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- stack_machine_with_variable_table_unit.f -----
src/smvt_pkg.sv
src/smvt_ctrl.sv
src/smvt_datapath.sv
src/stack_machine_with_variable_table_unit.sv
src/smvt_checker.sv
sim/tb_top.sv
